// ===== sv/vsw_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsw_pkg
// Shared types and constants of the volume slice window colormap block.
// ---------------------------------------------------------------------------
package vsw_pkg;

    localparam int COORD_W = 7;
    localparam int SAMP_IN_W = 16;
    localparam int LIMIT_W = 16;
    localparam int COLOR_W = 8;
    localparam int COUNT_W = 9;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;

    // Request codes
    localparam logic [1:0] REQ_VOXEL = 2'd0;
    localparam logic [1:0] REQ_COLOR = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_PIXEL = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd7;

    // Orientation codes
    localparam logic [1:0] ORI_SAGITTAL = 2'd1;
    localparam logic [1:0] ORI_CORONAL = 2'd2;

    // Alpha modes
    localparam logic [1:0] ALPHA_OPAQUE = 2'd0;
    localparam logic [1:0] ALPHA_INDEX = 2'd1;

    localparam logic [COLOR_W-1:0] ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [COORD_W-1:0]   coord_a;
        logic [COORD_W-1:0]   coord_b;
        logic [COORD_W-1:0]   coord_c;
        logic [COORD_W-1:0]   end_a;
        logic [COORD_W-1:0]   end_b;
        logic [COORD_W-1:0]   end_c;
        logic [SAMP_IN_W-1:0] sample;
        logic [COLOR_W-1:0]   red_in;
        logic [COLOR_W-1:0]   green_in;
        logic [COLOR_W-1:0]   blue_in;
    } t_req;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
        logic               alpha_present;
        logic               last;
    } t_pix;

    // Window setup handed to the mapping unit
    typedef struct packed {
        logic [LIMIT_W-1:0] low;
        logic [LIMIT_W-1:0] high;
        logic [COUNT_W-1:0] count;
    } t_win_cfg;

endpackage

// ===== sv/vsw_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsw_req_if
// Request channel: valid/ready handshake with a request payload.
// ---------------------------------------------------------------------------
interface vsw_req_if;
    import vsw_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/vsw_pix_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsw_pix_if
// Pixel channel: valid/ready handshake with a pixel payload.
// ---------------------------------------------------------------------------
interface vsw_pix_if;
    import vsw_pkg::*;
    logic valid;
    logic ready;
    t_pix data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/vsw_voxel_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsw_voxel_mem
// Voxel store: one write and one registered read per cycle, range checked.
// ---------------------------------------------------------------------------
module vsw_voxel_mem #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [vsw_pkg::COORD_W-1:0] i_wx,
    input  logic [vsw_pkg::COORD_W-1:0] i_wy,
    input  logic [vsw_pkg::COORD_W-1:0] i_wz,
    input  logic [SAMPLE_BITS-1:0]      i_wdata,
    input  logic                        i_re,
    input  logic [vsw_pkg::COORD_W-1:0] i_rx,
    input  logic [vsw_pkg::COORD_W-1:0] i_ry,
    input  logic [vsw_pkg::COORD_W-1:0] i_rz,
    output logic [SAMPLE_BITS-1:0]      o_rdata
);
    import vsw_pkg::*;

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rdata;
    logic                   r_oob;
    logic                   w_in;
    logic                   r_in;
    logic [AW-1:0]          w_addr;
    logic [AW-1:0]          r_addr;

    // Range checks against the memory extent
    assign w_in = (32'(i_wx) < MAX_X) && (32'(i_wy) < MAX_Y) && (32'(i_wz) < MAX_Z);
    assign r_in = (32'(i_rx) < MAX_X) && (32'(i_ry) < MAX_Y) && (32'(i_rz) < MAX_Z);

    // Linear address: plane, then row, then column
    assign w_addr = AW'((AW'(i_wz) * AW'(MAX_Y) + AW'(i_wy)) * AW'(MAX_X) + AW'(i_wx));
    assign r_addr = AW'((AW'(i_rz) * AW'(MAX_Y) + AW'(i_ry)) * AW'(MAX_X) + AW'(i_rx));

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we && w_in) begin
            r_mem[w_addr] <= i_wdata;
        end
    end

    // Read port, out-of-range reads answer zero
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_oob <= !r_in;
            if (r_in) begin
                r_rdata <= r_mem[r_addr];
            end
        end
    end

    assign o_rdata = r_oob ? '0 : r_rdata;
endmodule

// ===== sv/vsw_color_lut.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsw_color_lut
// Color table: one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module vsw_color_lut #(
    parameter int TABLE_ENTRIES = 256,
    parameter int IDX_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [vsw_pkg::COORD_W-1:0] i_waddr,
    input  logic [3*vsw_pkg::COLOR_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [IDX_W-1:0]            i_raddr,
    output logic [3*vsw_pkg::COLOR_W-1:0] o_rdata
);
    import vsw_pkg::*;

    logic [3*COLOR_W-1:0] r_mem [TABLE_ENTRIES];
    logic [3*COLOR_W-1:0] r_rdata;

    // Drop writes beyond the table
    always_ff @(posedge i_clk) begin
        if (i_we && (32'(i_waddr) < TABLE_ENTRIES)) begin
            r_mem[IDX_W'(i_waddr)] <= i_wdata;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/vsw_window.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsw_window
// Window mapping: sample to color index through a multiply and a
// restoring divider that resolves one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vsw_window #(
    parameter int TABLE_ENTRIES = 256,
    parameter int IDX_W = 8,
    parameter int VW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [VW-1:0]       i_sample,
    input  vsw_pkg::t_win_cfg   i_cfg,
    output logic                o_done,
    output logic [IDX_W-1:0]    o_idx
);
    import vsw_pkg::*;

    localparam int NW = IDX_W + LIMIT_W;
    localparam int CW = $clog2(IDX_W + 1);

    typedef enum logic [1:0] {W_IDLE, W_MUL, W_DIV} t_wstate;

    t_wstate            r_state;
    logic               r_done;
    logic [IDX_W-1:0]   r_quo;
    logic [LIMIT_W-1:0] r_rem;
    logic [LIMIT_W-1:0] r_den;
    logic [LIMIT_W-1:0] r_diff;
    logic [IDX_W-1:0]   r_nm1;
    logic [CW-1:0]      r_cnt;
    logic [COUNT_W-1:0] w_n;
    logic [IDX_W-1:0]   w_nm1;
    logic               w_inside;
    logic               w_above;
    logic [NW-1:0]      w_prod;
    logic [LIMIT_W:0]   w_trial;
    logic               w_fit;

    // Clamp the color count to 1 .. TABLE_ENTRIES
    always_comb begin
        if (i_cfg.count == '0) begin
            w_n = COUNT_W'(1);
        end else if (32'(i_cfg.count) > TABLE_ENTRIES) begin
            w_n = COUNT_W'(TABLE_ENTRIES);
        end else begin
            w_n = i_cfg.count;
        end
    end
    assign w_nm1 = IDX_W'(w_n - COUNT_W'(1));

    assign w_inside = (i_sample > VW'(i_cfg.low)) && (i_sample < VW'(i_cfg.high));
    assign w_above = (i_sample >= VW'(i_cfg.high));

    assign w_prod = NW'(r_nm1) * NW'(r_diff);
    assign w_trial = {r_rem, r_quo[IDX_W-1]};
    assign w_fit = (w_trial >= {1'b0, r_den});

    // Sequence multiply and divide steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                W_IDLE: begin
                    if (i_start) begin
                        if (w_inside) begin
                            r_diff <= LIMIT_W'(i_sample - VW'(i_cfg.low));
                            r_den <= i_cfg.high - i_cfg.low;
                            r_nm1 <= w_nm1;
                            r_state <= W_MUL;
                        end else begin
                            r_quo <= w_above ? w_nm1 : '0;
                            r_done <= 1'b1;
                        end
                    end
                end
                W_MUL: begin
                    // Upper product bits are below the divisor
                    r_rem <= w_prod[NW-1:IDX_W];
                    r_quo <= w_prod[IDX_W-1:0];
                    r_cnt <= CW'(IDX_W);
                    r_state <= W_DIV;
                end
                W_DIV: begin
                    r_rem <= w_fit ? LIMIT_W'(w_trial - {1'b0, r_den})
                                   : LIMIT_W'(w_trial);
                    r_quo <= (r_quo << 1) | IDX_W'(w_fit);
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_done <= 1'b1;
                        r_state <= W_IDLE;
                    end
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_idx = r_quo;
endmodule

// ===== sv/volume_slice_window_colormap.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// volume_slice_window_colormap
// Reslices a stored voxel volume through a box and maps each voxel to RGB, with alpha in the opaque and index modes.
// ---------------------------------------------------------------------------
// Voxel writes, color writes and box starts are taken in the idle state and leave
// it unchanged. A pixel request reads the voxel store, maps the sample in the
// window unit (through its bit-serial divider when the sample lies inside the
// open window) and reads the color table; the voxel store and the color table
// each give a registered read. One request is in flight at a time; the pixel
// register lets the next request in while a pixel waits to be taken. The
// memories need no clearing pass after reset.
module volume_slice_window_colormap #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64,
    parameter int TABLE_ENTRIES = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vsw_req_if.sink                       i_req,
    vsw_pix_if.source                     o_pix,
    input  logic                          i_cfg_we,
    input  logic [vsw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vsw_pkg::CFG_W-1:0]     i_cfg_data
);
    import vsw_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int VW = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_WIN, S_LUT} t_state;

    // Configuration registers
    logic [1:0]         r_orient;
    logic [LIMIT_W-1:0] r_low;
    logic [LIMIT_W-1:0] r_high;
    logic [1:0]         r_amode;
    logic [COUNT_W-1:0] r_count;
    logic [COORD_W-1:0] r_size_x;
    logic [COORD_W-1:0] r_size_y;
    logic [COORD_W-1:0] r_size_z;

    // Walk state
    t_state             r_state;
    logic               r_walk;
    logic [COORD_W-1:0] r_pw, r_ph, r_pd;
    logic [COORD_W-1:0] r_ws, r_we, r_hs, r_he, r_ds, r_de;
    logic               r_last;
    logic [IDX_W-1:0]   r_idx;
    logic               r_ovalid;
    t_pix               r_opix;

    logic               w_acc;
    logic [COORD_W-1:0] w_ext [3];
    logic [COORD_W-1:0] w_st [3];
    logic [COORD_W-1:0] w_en [3];
    logic [COORD_W-1:0] w_rx, w_ry, w_rz;
    logic [COORD_W:0]   w_pw_inc;
    logic               w_pix_go;
    logic               w_out_free;
    logic [SAMPLE_BITS-1:0] w_vox;
    logic               w_win_done;
    logic [IDX_W-1:0]   w_win_idx;
    logic [3*COLOR_W-1:0] w_rgb;
    t_win_cfg           w_wcfg;

    function automatic logic [COORD_W-1:0] f_clamp(input logic [COORD_W-1:0] v,
                                                   input int mx);
        logic [COORD_W-1:0] res;
        if (v == '0) begin
            res = COORD_W'(1);
        end else if (32'(v) > mx) begin
            res = COORD_W'(mx);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign w_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_pix_go = w_acc && (i_req.data.req_type == REQ_PIXEL) && r_walk;
    assign w_out_free = !r_ovalid || o_pix.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= '0;
            r_low <= '0;
            r_high <= '1;
            r_amode <= '0;
            r_count <= COUNT_W'(256);
            r_size_x <= COORD_W'(64);
            r_size_y <= COORD_W'(64);
            r_size_z <= COORD_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIENT: r_orient <= i_cfg_data[1:0];
                REG_LOW:    r_low <= i_cfg_data;
                REG_HIGH:   r_high <= i_cfg_data;
                REG_ALPHA:  r_amode <= i_cfg_data[1:0];
                REG_COUNT:  r_count <= i_cfg_data[COUNT_W-1:0];
                REG_SIZE_X: r_size_x <= i_cfg_data[COORD_W-1:0];
                REG_SIZE_Y: r_size_y <= i_cfg_data[COORD_W-1:0];
                REG_SIZE_Z: r_size_z <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Display extents and box ends for a start
    always_comb begin
        case (r_orient)
            ORI_SAGITTAL: begin
                w_ext[0] = f_clamp(r_size_y, MAX_Y);
                w_ext[1] = f_clamp(r_size_z, MAX_Z);
                w_ext[2] = f_clamp(r_size_x, MAX_X);
            end
            ORI_CORONAL: begin
                w_ext[0] = f_clamp(r_size_x, MAX_X);
                w_ext[1] = f_clamp(r_size_z, MAX_Z);
                w_ext[2] = f_clamp(r_size_y, MAX_Y);
            end
            default: begin
                w_ext[0] = f_clamp(r_size_x, MAX_X);
                w_ext[1] = f_clamp(r_size_y, MAX_Y);
                w_ext[2] = f_clamp(r_size_z, MAX_Z);
            end
        endcase
        w_st[0] = i_req.data.coord_a;
        w_st[1] = i_req.data.coord_b;
        w_st[2] = i_req.data.coord_c;
        w_en[0] = i_req.data.end_a;
        w_en[1] = i_req.data.end_b;
        w_en[2] = i_req.data.end_c;
        for (int i = 0; i < 3; i++) begin
            if (w_en[i] == '0 || w_en[i] > w_ext[i]) begin
                w_en[i] = w_ext[i];
            end
        end
    end

    // Map display position to volume axes
    always_comb begin
        case (r_orient)
            ORI_SAGITTAL: begin
                w_rx = r_pd; w_ry = r_pw; w_rz = r_ph;
            end
            ORI_CORONAL: begin
                w_rx = r_pw; w_ry = r_pd; w_rz = r_ph;
            end
            default: begin
                w_rx = r_pw; w_ry = r_ph; w_rz = r_pd;
            end
        endcase
    end

    assign w_pw_inc = {1'b0, r_pw} + (COORD_W + 1)'(1);

    // Sequence requests, advance the walk, load the pixel register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_walk <= 1'b0;
            r_pw <= '0; r_ph <= '0; r_pd <= '0;
            r_ws <= '0; r_we <= '0; r_hs <= '0;
            r_he <= '0; r_ds <= '0; r_de <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Drop a taken pixel unless a new one is loaded this cycle
            if (r_ovalid && o_pix.ready && r_state != S_LUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_req.data.req_type == REQ_START) begin
                        r_ws <= w_st[0]; r_we <= w_en[0];
                        r_hs <= w_st[1]; r_he <= w_en[1];
                        r_ds <= w_st[2]; r_de <= w_en[2];
                        r_walk <= (w_st[0] < w_en[0]) && (w_st[1] < w_en[1])
                                  && (w_st[2] < w_en[2]);
                        r_pw <= w_st[0];
                        r_ph <= w_en[1] - COORD_W'(1);
                        r_pd <= w_en[2] - COORD_W'(1);
                    end else if (w_pix_go) begin
                        r_last <= (w_pw_inc >= {1'b0, r_we}) && (r_ph <= r_hs)
                                  && (r_pd <= r_ds);
                        r_state <= S_READ;
                        if (w_pw_inc >= {1'b0, r_we}) begin
                            r_pw <= r_ws;
                            if (r_ph <= r_hs) begin
                                r_ph <= r_he - COORD_W'(1);
                                if (r_pd <= r_ds) begin
                                    r_walk <= 1'b0;
                                end else begin
                                    r_pd <= r_pd - COORD_W'(1);
                                end
                            end else begin
                                r_ph <= r_ph - COORD_W'(1);
                            end
                        end else begin
                            r_pw <= COORD_W'(w_pw_inc);
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    if (w_win_done) begin
                        r_idx <= w_win_idx;
                        r_state <= S_LUT;
                    end
                end
                S_LUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_opix.red <= w_rgb[3*COLOR_W-1:2*COLOR_W];
                        r_opix.green <= w_rgb[2*COLOR_W-1:COLOR_W];
                        r_opix.blue <= w_rgb[COLOR_W-1:0];
                        r_opix.last <= r_last;
                        if (r_amode == ALPHA_OPAQUE) begin
                            r_opix.alpha <= ALPHA_FULL;
                            r_opix.alpha_present <= 1'b1;
                        end else if (r_amode == ALPHA_INDEX) begin
                            r_opix.alpha <= COLOR_W'(r_idx);
                            r_opix.alpha_present <= 1'b1;
                        end else begin
                            r_opix.alpha <= '0;
                            r_opix.alpha_present <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_pix.valid = r_ovalid;
    assign o_pix.data = r_opix;

    assign w_wcfg.low = r_low;
    assign w_wcfg.high = r_high;
    assign w_wcfg.count = r_count;

    vsw_voxel_mem #(
        .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_voxel (
        .i_clk   (i_clk),
        .i_we    (w_acc && i_req.data.req_type == REQ_VOXEL),
        .i_wx    (i_req.data.coord_a),
        .i_wy    (i_req.data.coord_b),
        .i_wz    (i_req.data.coord_c),
        .i_wdata (SAMPLE_BITS'(i_req.data.sample)),
        .i_re    (w_pix_go),
        .i_rx    (w_rx),
        .i_ry    (w_ry),
        .i_rz    (w_rz),
        .o_rdata (w_vox)
    );

    vsw_window #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W), .VW(VW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_READ),
        .i_sample (VW'(w_vox)),
        .i_cfg    (w_wcfg),
        .o_done   (w_win_done),
        .o_idx    (w_win_idx)
    );

    vsw_color_lut #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)
    ) u_lut (
        .i_clk   (i_clk),
        .i_we    (w_acc && i_req.data.req_type == REQ_COLOR),
        .i_waddr (i_req.data.coord_a),
        .i_wdata ({i_req.data.red_in, i_req.data.green_in, i_req.data.blue_in}),
        .i_re    (r_state == S_WIN && w_win_done),
        .i_raddr (w_win_idx),
        .o_rdata (w_rgb)
    );
endmodule
